/* rtl/cgep_pkg.sv */
// Shared types and constants for the grid exit walk counter.
// Used by the front, back, top level and checker; depends on nothing.
package cgep_pkg;

	localparam logic [29:0] WALK_MOD = 30'd1000000007;
	localparam int IDX_W = 8;

	localparam logic [1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [1:0] REG_GRID_COLS = 2'd1;

	typedef struct packed {
		logic [7:0] max_moves;
		logic [5:0] start_row;
		logic [5:0] start_col;
	} req_t;

	typedef struct packed {
		logic [29:0] path_count;
		logic        start_error;
	} res_t;

	// One classified request as it waits between front and back.
	typedef struct packed {
		logic [7:0]       max_moves;
		logic [5:0]       start_row;
		logic [5:0]       start_col;
		logic [IDX_W-1:0] row_last;
		logic [IDX_W-1:0] col_last;
		logic             start_error;
	} job_t;

	function automatic logic [29:0] mod_add(input logic [29:0] a, input logic [29:0] b);
		logic [30:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, WALK_MOD})
			s = s - {1'b0, WALK_MOD};
		return s[29:0];
	endfunction

endpackage

/* rtl/cgep_front.sv */
// Front end: configuration registers, request transfer, start cell check and
// a two-entry job queue toward the back end. Depends on cgep_pkg.
module cgep_front import cgep_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       job_valid,
	output job_t       job,
	input  logic       job_pop
);

	logic [6:0] rows_q, cols_q;
	logic [8:0] rows9, cols9;
	logic [IDX_W-1:0] row_last, col_last;
	job_t in_job;
	job_t fifo_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd1;
			cols_q <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_ROWS: rows_q <= cfg_data;
				REG_GRID_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero size counts as one; a size above the store counts as the store size.
	always_comb begin
		rows9 = {2'b00, rows_q};
		cols9 = {2'b00, cols_q};
		if (rows_q == 7'd0)
			row_last = '0;
		else if (rows9 > 9'(MAX_ROWS))
			row_last = IDX_W'(MAX_ROWS - 1);
		else
			row_last = IDX_W'(rows9 - 9'd1);
		if (cols_q == 7'd0)
			col_last = '0;
		else if (cols9 > 9'(MAX_COLS))
			col_last = IDX_W'(MAX_COLS - 1);
		else
			col_last = IDX_W'(cols9 - 9'd1);
		in_job.max_moves   = req.max_moves;
		in_job.start_row   = req.start_row;
		in_job.start_col   = req.start_col;
		in_job.row_last    = row_last;
		in_job.col_last    = col_last;
		in_job.start_error = (IDX_W'(req.start_row) > row_last) ||
			(IDX_W'(req.start_col) > col_last);
	end

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;
	assign job_valid = (count_q != 2'd0);
	assign job = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (job_pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(job_pop);
		end
	end

endmodule

/* rtl/cgep_back.sv */
// Back end: sweeps the ping-pong walk-count layers one cell at a time and
// drives the result strobe. Depends on cgep_pkg.
module cgep_back import cgep_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic done,
	output res_t result
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INIT = 2'd1;
	localparam logic [1:0] S_MOVE = 2'd2;

	logic [1:0]  state_q;
	job_t        job_q;
	logic [RW-1:0] r_q, rd_r, r_last;
	logic [CW-1:0] c_q, rd_c, c_last;
	logic [2:0]  ph_q;
	logic [7:0]  mv_q;
	logic        sel_q;
	logic [29:0] ex_q, acc_q, w_q, acc_n, ex_n, rdata, rd0_q, rd1_q, wdata;
	logic        dir_in, last_cell, we, wsel, done_q;
	logic [AW-1:0] rd_addr, wr_addr;
	res_t        res_q;
	logic [29:0] mem0 [DEPTH];
	logic [29:0] mem1 [DEPTH];

	assign r_last = job_q.row_last[RW-1:0];
	assign c_last = job_q.col_last[CW-1:0];
	assign last_cell = (r_q == r_last) && (c_q == c_last);
	assign job_pop = (state_q == S_IDLE) && job_valid;

	// Phase 0 reads the cell itself, phases 1 to 4 its four neighbors; each read
	// lands one phase later.
	always_comb begin
		rd_r = r_q;
		rd_c = c_q;
		case (ph_q)
			3'd1: rd_r = r_q - 1'b1;
			3'd2: rd_r = r_q + 1'b1;
			3'd3: rd_c = c_q - 1'b1;
			3'd4: rd_c = c_q + 1'b1;
			default: ;
		endcase
		case (ph_q)
			3'd2: dir_in = (r_q != '0);
			3'd3: dir_in = (r_q != r_last);
			3'd4: dir_in = (c_q != '0);
			3'd5: dir_in = (c_q != c_last);
			default: dir_in = 1'b0;
		endcase
	end

	assign rd_addr = AW'(rd_r * MAX_COLS + rd_c);
	assign wr_addr = AW'(r_q * MAX_COLS + c_q);
	assign rdata = sel_q ? rd1_q : rd0_q;
	assign acc_n = dir_in ? mod_add(acc_q, rdata) : acc_q;
	assign ex_n = dir_in ? ex_q : mod_add(ex_q, w_q);

	always_comb begin
		we = 1'b0;
		wsel = sel_q;
		wdata = acc_n;
		if (state_q == S_INIT) begin
			we = 1'b1;
			wdata = ((IDX_W'(r_q) == IDX_W'(job_q.start_row)) &&
				(IDX_W'(c_q) == IDX_W'(job_q.start_col))) ? 30'd1 : 30'd0;
		end else if (state_q == S_MOVE && ph_q == 3'd5) begin
			we = 1'b1;
			wsel = !sel_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we && !wsel)
			mem0[wr_addr] <= wdata;
		if (we && wsel)
			mem1[wr_addr] <= wdata;
		rd0_q <= mem0[rd_addr];
		rd1_q <= mem1[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			sel_q   <= 1'b0;
			ph_q    <= 3'd0;
			r_q     <= '0;
			c_q     <= '0;
			mv_q    <= 8'd0;
			ex_q    <= 30'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_pop) begin
						job_q <= job;
						if (job.start_error) begin
							res_q  <= '{path_count: 30'd0, start_error: 1'b1};
							done_q <= 1'b1;
						end else begin
							r_q <= '0;
							c_q <= '0;
							mv_q <= 8'd0;
							ex_q <= 30'd0;
							ph_q <= 3'd0;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					if (c_q == c_last) begin
						c_q <= '0;
						r_q <= last_cell ? '0 : r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
					if (last_cell) begin
						if (job_q.max_moves == 8'd0) begin
							res_q  <= '{path_count: 30'd0, start_error: 1'b0};
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MOVE;
						end
					end
				end
				S_MOVE: begin
					if (ph_q == 3'd1) begin
						w_q <= rdata;
						acc_q <= 30'd0;
					end else if (ph_q != 3'd0) begin
						acc_q <= acc_n;
						ex_q <= ex_n;
					end
					if (ph_q == 3'd5) begin
						ph_q <= 3'd0;
						if (c_q == c_last) begin
							c_q <= '0;
							r_q <= last_cell ? '0 : r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
						if (last_cell) begin
							sel_q <= !sel_q;
							mv_q <= mv_q + 8'd1;
							if (mv_q + 8'd1 == job_q.max_moves) begin
								res_q  <= '{path_count: ex_n, start_error: 1'b0};
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

/* rtl/count_grid_exit_paths_core.sv */
// Top level of the grid exit walk counter: front end, job queue and back end.
// Depends on cgep_pkg, cgep_front and cgep_back.
//
// A request (moves, start cell) is taken when start is high and busy is low;
// up to two requests wait in a queue while one is worked on. Each request gives
// one result on result, marked by a single-cycle done strobe that the receiver
// must take as it comes. A start cell outside the grid gives start_error with a
// zero count, in order behind earlier requests. Otherwise the back end loads
// the first layer one cell at a time and then, for each move, visits each cell
// and its four neighbors in turn through a single read address. Grid size
// writes take effect for requests transferred after them; cfg_ready is always
// high.
module count_grid_exit_paths_core import cgep_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       done,
	output res_t       result
);

	logic job_valid, job_pop;
	job_t job;

	cgep_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .job_valid(job_valid), .job(job), .job_pop(job_pop)
	);

	cgep_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_pop(job_pop), .done(done), .result(result)
	);

endmodule

/* rtl/cgep_checker.sv */
// Port-level checks for the grid exit walk counter, bound to the top level.
// Depends on cgep_pkg.
module cgep_checker import cgep_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic done,
	input res_t result
);

	// An out-of-grid start always reports a zero count.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.start_error |-> result.path_count == 30'd0)
		else $error("start error with nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.path_count < WALK_MOD)
		else $error("count not reduced");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	// The queue starts empty, so the first cycle out of reset cannot be busy.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !busy)
		else $error("busy right after reset");

endmodule

bind count_grid_exit_paths_core cgep_checker u_cgep_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready), .done(done), .result(result)
);
